// File: hw/rtl/adse_pkg.sv
`default_nettype none
package adse_pkg;

  localparam logic [7:0]  TYPE_MANUFACTURER = 8'hFF;
  localparam logic [15:0] GROUP_FREQUENCY   = 16'hF72D;
  localparam logic [7:0]  SENSOR_ID_LUX     = 8'h03;
  localparam logic [7:0]  SENSOR_ID_HUMID   = 8'h05;
  localparam logic [7:0]  SENSOR_ID_GROUP   = 8'h18;
  localparam logic [16:0] TEMP_OFFSET       = 17'd50;
  localparam logic [7:0]  POS_MAX           = 8'd255;
  localparam logic [1:0]  COUNT_ALL         = 2'd3;

  localparam logic [2:0] KIND_LUX         = 3'd0;
  localparam logic [2:0] KIND_HUMID       = 3'd1;
  localparam logic [2:0] KIND_GROUP_FREQ  = 3'd2;
  localparam logic [2:0] KIND_GROUP_OTHER = 3'd3;
  localparam logic [2:0] KIND_OTHER_ID    = 3'd4;
  localparam logic [2:0] KIND_COMPANY     = 3'd5;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic       fmt;
    logic [7:0] pos;
    logic [7:0] epos;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        maker_id;
    logic [7:0]         sensor_id;
    logic [2:0]         decode_kind;
    logic signed [16:0] temperature;
    logic [15:0]        luminosity;
    logic [15:0]        humidity;
    logic [7:0]         battery;
    logic [15:0]        group_number;
    logic [31:0]        frequency;
    logic               short_structure;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/adse_fifo.sv
`default_nettype none
module adse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/adse_front.sv
`default_nettype none
module adse_front #(
  parameter int MAX_EXAMINED_STRUCTS = 3
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     payload_byte,
  input  wire logic           packet_end,
  input  wire logic           sensor_tag_format,
  output logic                cmd_push,
  output adse_pkg::cmd_t      cmd
);

  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] struct_pos_r, struct_pos_nxt;
  logic [1:0] struct_count_r, struct_count_nxt;
  logic       is_manuf_r, is_manuf_nxt;
  logic       fmt_r, fmt_nxt;
  logic       ended;
  logic       take;
  logic       emit;
  logic [7:0] emit_pos;

  always_comb begin
    bytes_left_nxt   = bytes_left_r;
    struct_pos_nxt   = struct_pos_r;
    struct_count_nxt = struct_count_r;
    is_manuf_nxt     = is_manuf_r;
    fmt_nxt          = fmt_r;
    ended            = 1'b0;
    take             = 1'b0;
    if (bytes_left_r == '0) begin
      if (struct_count_r == '0) begin
        fmt_nxt = sensor_tag_format;
      end
      if (payload_byte == '0) begin
        struct_count_nxt = adse_pkg::COUNT_ALL;
        is_manuf_nxt     = 1'b0;
      end else begin
        is_manuf_nxt = (struct_count_r < 2'(MAX_EXAMINED_STRUCTS));
        if (struct_count_r < adse_pkg::COUNT_ALL) begin
          struct_count_nxt = struct_count_r + 1'b1;
        end
        bytes_left_nxt = payload_byte;
        struct_pos_nxt = '0;
      end
    end else begin
      if (struct_pos_r == '0) begin
        is_manuf_nxt = is_manuf_r && (payload_byte == adse_pkg::TYPE_MANUFACTURER);
      end else begin
        take = is_manuf_r;
      end
      if (struct_pos_r < adse_pkg::POS_MAX) begin
        struct_pos_nxt = struct_pos_r + 1'b1;
      end
      bytes_left_nxt = bytes_left_r - 1'b1;
      ended          = (bytes_left_nxt == '0);
    end
    if (packet_end) begin
      ended = 1'b1;
    end
    emit     = ended && is_manuf_nxt && (struct_pos_nxt != '0);
    emit_pos = struct_pos_nxt;
    if (ended) begin
      is_manuf_nxt = 1'b0;
    end
    if (packet_end) begin
      bytes_left_nxt   = '0;
      struct_pos_nxt   = '0;
      struct_count_nxt = '0;
      is_manuf_nxt     = 1'b0;
    end
  end

  always_comb begin
    cmd_push = accept && (take || emit);
    cmd.take = take;
    cmd.emit = emit;
    cmd.fmt  = fmt_nxt;
    cmd.pos  = struct_pos_r;
    cmd.epos = emit_pos;
    cmd.data = payload_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r   <= '0;
      struct_pos_r   <= '0;
      struct_count_r <= '0;
      is_manuf_r     <= 1'b0;
      fmt_r          <= 1'b0;
    end else if (accept) begin
      bytes_left_r   <= bytes_left_nxt;
      struct_pos_r   <= struct_pos_nxt;
      struct_count_r <= struct_count_nxt;
      is_manuf_r     <= is_manuf_nxt;
      fmt_r          <= fmt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/adse_back.sv
`default_nettype none
module adse_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire adse_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output adse_pkg::res_t      res
);

  logic [15:0]        company_r, company_nxt;
  logic [7:0]         sensor_id_r, sensor_id_nxt;
  logic signed [16:0] temp_r, temp_nxt;
  logic [15:0]        lux_r, lux_nxt;
  logic [15:0]        humid_r, humid_nxt;
  logic [7:0]         battery_r, battery_nxt;
  logic [15:0]        group_r, group_nxt;
  logic [31:0]        freq_r, freq_nxt;
  logic [31:0]        shift_r, shift_nxt;
  logic               go;
  logic [7:0]         b;
  logic [7:0]         p;
  logic [15:0]        pair;
  logic [2:0]         kind;
  logic [7:0]         need;

  assign go       = cmd_valid && (!cmd.emit || !res_full);
  assign cmd_pop  = go;
  assign res_push = go && cmd.emit;
  assign b        = cmd.data;
  assign p        = cmd.pos;
  assign pair     = shift_r[15:0] | {b, 8'h00};

  always_comb begin
    company_nxt   = company_r;
    sensor_id_nxt = sensor_id_r;
    temp_nxt      = temp_r;
    lux_nxt       = lux_r;
    humid_nxt     = humid_r;
    battery_nxt   = battery_r;
    group_nxt     = group_r;
    freq_nxt      = freq_r;
    shift_nxt     = shift_r;
    if (cmd.take) begin
      if (p == 8'd1) begin
        shift_nxt = {24'h0, b};
      end else if (p == 8'd2) begin
        company_nxt = pair;
      end else if (cmd.fmt) begin
        if (p == 8'd3) begin
          sensor_id_nxt = b;
        end else if (sensor_id_r == adse_pkg::SENSOR_ID_LUX) begin
          if (p == 8'd4 || p == 8'd6) begin
            shift_nxt = {24'h0, b};
          end else if (p == 8'd5) begin
            temp_nxt = $signed({1'b0, pair});
          end else if (p == 8'd7) begin
            lux_nxt = pair;
          end else if (p == 8'd8) begin
            battery_nxt = b;
          end
        end else if (sensor_id_r == adse_pkg::SENSOR_ID_HUMID) begin
          if (p == 8'd4 || p == 8'd8) begin
            shift_nxt = {24'h0, b};
          end else if (p == 8'd5) begin
            temp_nxt = $signed({1'b0, pair});
          end else if (p == 8'd9) begin
            humid_nxt = pair;
          end else if (p == 8'd10) begin
            battery_nxt = b;
          end
        end else if (sensor_id_r == adse_pkg::SENSOR_ID_GROUP) begin
          if (p == 8'd4) begin
            shift_nxt = {24'h0, b};
          end else if (p == 8'd5) begin
            group_nxt = pair;
          end else if (group_r == adse_pkg::GROUP_FREQUENCY) begin
            if (p == 8'd6) begin
              shift_nxt = {24'h0, b};
            end else if (p == 8'd7) begin
              shift_nxt = shift_r | {16'h0, b, 8'h00};
            end else if (p == 8'd8) begin
              shift_nxt = shift_r | {8'h0, b, 16'h0000};
            end else if (p == 8'd9) begin
              freq_nxt = shift_r | {b, 24'h000000};
            end else if (p == 8'd10) begin
              temp_nxt = $signed({9'h0, b} - adse_pkg::TEMP_OFFSET);
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (!cmd.fmt) begin
      kind = adse_pkg::KIND_COMPANY;
      need = 8'd3;
    end else if (cmd.epos < 8'd4) begin
      kind = adse_pkg::KIND_COMPANY;
      need = 8'd4;
    end else if (sensor_id_nxt == adse_pkg::SENSOR_ID_LUX) begin
      kind = adse_pkg::KIND_LUX;
      need = 8'd9;
    end else if (sensor_id_nxt == adse_pkg::SENSOR_ID_HUMID) begin
      kind = adse_pkg::KIND_HUMID;
      need = 8'd11;
    end else if (sensor_id_nxt == adse_pkg::SENSOR_ID_GROUP) begin
      if (cmd.epos >= 8'd6 && group_nxt == adse_pkg::GROUP_FREQUENCY) begin
        kind = adse_pkg::KIND_GROUP_FREQ;
        need = 8'd11;
      end else begin
        kind = adse_pkg::KIND_GROUP_OTHER;
        need = 8'd6;
      end
    end else begin
      kind = adse_pkg::KIND_OTHER_ID;
      need = 8'd4;
    end
  end

  always_comb begin
    res.maker_id        = company_nxt;
    res.sensor_id       = sensor_id_nxt;
    res.decode_kind     = kind;
    res.temperature     = temp_nxt;
    res.luminosity      = lux_nxt;
    res.humidity        = humid_nxt;
    res.battery         = battery_nxt;
    res.group_number    = group_nxt;
    res.frequency       = freq_nxt;
    res.short_structure = (cmd.epos < need);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      company_r   <= '0;
      sensor_id_r <= '0;
      temp_r      <= '0;
      lux_r       <= '0;
      humid_r     <= '0;
      battery_r   <= '0;
      group_r     <= '0;
      freq_r      <= '0;
      shift_r     <= '0;
    end else if (go) begin
      company_r   <= company_nxt;
      sensor_id_r <= sensor_id_nxt;
      temp_r      <= temp_nxt;
      lux_r       <= lux_nxt;
      humid_r     <= humid_nxt;
      battery_r   <= battery_nxt;
      group_r     <= group_nxt;
      freq_r      <= freq_nxt;
      shift_r     <= shift_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/adv_data_sensor_extractor.sv
// Parses advertising payload words one per clock: each accepted word is a payload byte, and
// in_packet_end marks the last one of a packet. The front end tracks the length-type
// structures and passes the bytes of examined manufacturer structures through a short command
// queue to the back end, which holds the persistent sensor record and writes one result word
// per examined manufacturer structure into the result queue. A word can be accepted every
// cycle as long as the result side keeps up; a result reaches the out_ ports through the
// command queue and the result queue registers.
`default_nettype none
module adv_data_sensor_extractor #(
  parameter int MAX_EXAMINED_STRUCTS = 3,
  parameter int CMD_DEPTH            = 2,
  parameter int RES_DEPTH            = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [7:0]         in_payload_byte,
  input  wire logic               in_packet_end,
  input  wire logic               in_sensor_tag_format,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [15:0]             out_maker_id,
  output logic [7:0]              out_sensor_id,
  output logic [2:0]              out_decode_kind,
  output logic signed [16:0]      out_temperature,
  output logic [15:0]             out_luminosity,
  output logic [15:0]             out_humidity,
  output logic [7:0]              out_battery,
  output logic [15:0]             out_group_number,
  output logic [31:0]             out_frequency,
  output logic                    out_short_structure
);

  localparam int CMD_W = $bits(adse_pkg::cmd_t);
  localparam int RES_W = $bits(adse_pkg::res_t);

  adse_pkg::cmd_t   front_cmd;
  adse_pkg::cmd_t   back_cmd;
  adse_pkg::res_t   back_res;
  adse_pkg::res_t   out_res;
  logic             accept;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  logic [CMD_W-1:0] cmd_rd_data;
  logic [RES_W-1:0] res_rd_data;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  adse_front #(
    .MAX_EXAMINED_STRUCTS(MAX_EXAMINED_STRUCTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .payload_byte     (in_payload_byte),
    .packet_end       (in_packet_end),
    .sensor_tag_format(in_sensor_tag_format),
    .cmd_push         (cmd_push),
    .cmd              (front_cmd)
  );

  adse_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_data(front_cmd),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_data(cmd_rd_data),
    .empty  (cmd_empty)
  );

  assign back_cmd = cmd_rd_data;

  adse_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!cmd_empty),
    .cmd      (back_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  adse_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(back_res),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(res_rd_data),
    .empty  (out_empty)
  );

  assign out_res             = res_rd_data;
  assign out_maker_id        = out_res.maker_id;
  assign out_sensor_id       = out_res.sensor_id;
  assign out_decode_kind     = out_res.decode_kind;
  assign out_temperature     = out_res.temperature;
  assign out_luminosity      = out_res.luminosity;
  assign out_humidity        = out_res.humidity;
  assign out_battery         = out_res.battery;
  assign out_group_number    = out_res.group_number;
  assign out_frequency       = out_res.frequency;
  assign out_short_structure = out_res.short_structure;

endmodule
`default_nettype wire
